### rtl/integral_image_generator_unit_macros.svh
// Assertion macros of the integral image generator RTL.
`ifndef INTEGRAL_IMAGE_GENERATOR_UNIT_MACROS_SVH
`define INTEGRAL_IMAGE_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define IIG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define IIG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/iig_pkg.sv
// Package with the types and fixed constants of the integral image generator.
package iig_pkg;

    localparam int PIXEL_W      = 8;
    localparam int PIXEL_SQ_W   = 16;
    localparam int ROW_SUM_W    = 18;
    localparam int ROW_SQ_W     = 26;
    localparam int AREA_SUM_W   = 28;
    localparam int AREA_SQ_W    = 36;

    localparam int CFG_DATA_W   = 11;
    localparam int CFG_INDEX_W  = 1;

    localparam int FRAME_WIDTH_RESET  = 320;
    localparam int FRAME_HEIGHT_RESET = 240;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // One line-store entry: the finished sums of one column of the last row.
    typedef struct packed {
        logic [AREA_SUM_W-1:0] area_sum;
        logic [AREA_SQ_W-1:0]  area_square_sum;
    } area_sums_t;

endpackage

### rtl/iig_pixel_if.sv
// Pixel input channel of the integral image generator.
interface iig_pixel_if;
    import iig_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

### rtl/iig_result_if.sv
// Result output channel of the integral image generator.
interface iig_result_if;
    import iig_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [AREA_SUM_W-1:0] area_sum;
    logic [AREA_SQ_W-1:0]  area_square_sum;
    logic                  frame_last;

    modport source (output valid, output area_sum, output area_square_sum,
                    output frame_last, input ready);
    modport sink (input valid, input area_sum, input area_square_sum,
                  input frame_last, output ready);
endinterface

### rtl/integral_image_generator_unit.sv
// Top level of the integral image generator (summed-area table with squares).
//
//   Channel        Direction  Handshake        Contents
//   pixel_stream   in         valid / ready    pixel, raster order
//   result_stream  out        valid / ready    area_sum, area_square_sum, frame_last
//   wr_*           in         wr_en only       frame_width (0), frame_height (1)
//
// The unit takes one pixel per clock while the output is not stalled and
// returns one result per pixel, via the middle stage and result register.
// The rate is set by the single read-modify-write per pixel on the line
// store, read at accept and written when the item leaves the middle stage.
// Reset clears the positions, the running row sums and all valid flags; the
// line store needs no clearing because row 0 never uses what it reads.
// A stall on the result side holds the result register and the middle stage,
// and the pixel input drops ready only when both are full.
`include "integral_image_generator_unit_macros.svh"

module integral_image_generator_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    iig_pixel_if.sink                        pixel_stream,
    iig_result_if.source                     result_stream,
    input  logic                             wr_en,
    input  logic [iig_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [iig_pkg::CFG_DATA_W-1:0]   wr_data
);
    import iig_pkg::*;

    // Column and row counters index up to the maximum size minus one; the
    // effective sizes need one more bit to hold the maximum itself.
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WIDTH_RESET  = (FRAME_WIDTH_RESET > MAX_WIDTH) ?
                                  MAX_WIDTH : FRAME_WIDTH_RESET;
    localparam int HEIGHT_RESET = (FRAME_HEIGHT_RESET > MAX_HEIGHT) ?
                                  MAX_HEIGHT : FRAME_HEIGHT_RESET;

    // Configuration: the registers keep the clamped sizes directly.
    logic [CW:0] width_reg,  width_next;
    logic [RW:0] height_reg, height_next;

    // Accept stage: positions and running row sums.
    logic [CW-1:0]         col_reg,    col_next;
    logic [RW-1:0]         row_reg,    row_next;
    logic [ROW_SUM_W-1:0]  rsum_reg,   rsum_next;
    logic [ROW_SQ_W-1:0]   rsq_reg,    rsq_next;

    // Middle stage: the item waits here for the line-store read data.
    logic                  s1_valid_reg,  s1_valid_next;
    logic [CW-1:0]         s1_col_reg;
    logic [ROW_SUM_W-1:0]  s1_rsum_reg;
    logic [ROW_SQ_W-1:0]   s1_rsq_reg;
    logic                  s1_above_reg;
    logic                  s1_last_reg;

    // Result register.
    logic                  out_valid_reg, out_valid_next;
    area_sums_t            out_sums_reg;
    logic                  out_last_reg;

    logic                  in_acc;
    logic                  s1_adv;
    logic                  row_end;
    logic                  frame_end;
    logic [PIXEL_SQ_W-1:0] pix_sq;
    logic [ROW_SUM_W-1:0]  rsum_cur;
    logic [ROW_SQ_W-1:0]   rsq_cur;
    area_sums_t            above;
    area_sums_t            ls_rd_data;
    area_sums_t            sums;

    // ------------------------------------------------------------------
    // Configuration writes, clamped to 1..MAX on the way in.
    // ------------------------------------------------------------------
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_FRAME_WIDTH:
                begin
                    if (wr_data == '0)
                        width_next = (CW+1)'(1);
                    else if (32'(wr_data) > MAX_WIDTH)
                        width_next = (CW+1)'(MAX_WIDTH);
                    else
                        width_next = (CW+1)'(wr_data);
                end
                REG_FRAME_HEIGHT:
                begin
                    if (wr_data == '0)
                        height_next = (RW+1)'(1);
                    else if (32'(wr_data) > MAX_HEIGHT)
                        height_next = (RW+1)'(MAX_HEIGHT);
                    else
                        height_next = (RW+1)'(wr_data);
                end
                default:
                begin
                    width_next  = width_reg;
                    height_next = height_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The middle stage moves on whenever the result register is
    // empty or being emptied, so a new pixel enters every cycle in steady
    // state.
    // ------------------------------------------------------------------
    assign s1_adv             = s1_valid_reg && (!out_valid_reg || result_stream.ready);
    assign pixel_stream.ready = !s1_valid_reg || s1_adv;
    assign in_acc             = pixel_stream.valid && pixel_stream.ready;

    assign s1_valid_next  = in_acc || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && !result_stream.ready);

    // ------------------------------------------------------------------
    // Accept stage. The running row sums include the current pixel; they
    // restart at zero after the last pixel of a row.
    // ------------------------------------------------------------------
    assign pix_sq    = PIXEL_SQ_W'(pixel_stream.pixel) * PIXEL_SQ_W'(pixel_stream.pixel);
    assign rsum_cur  = rsum_reg + ROW_SUM_W'(pixel_stream.pixel);
    assign rsq_cur   = rsq_reg + ROW_SQ_W'(pix_sq);
    assign row_end   = ({1'b0, col_reg} + (CW+1)'(1)) >= width_reg;
    assign frame_end = ({1'b0, row_reg} + (RW+1)'(1)) >= height_reg;

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        rsum_next = rsum_reg;
        rsq_next  = rsq_reg;
        if (in_acc)
        begin
            if (row_end)
            begin
                col_next  = '0;
                rsum_next = '0;
                rsq_next  = '0;
                row_next  = frame_end ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next  = col_reg + CW'(1);
                rsum_next = rsum_cur;
                rsq_next  = rsq_cur;
            end
        end
    end

    // ------------------------------------------------------------------
    // Line store: read at accept, written back when the item leaves the
    // middle stage. The first row masks whatever the store returns.
    // ------------------------------------------------------------------
    iig_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_acc),
        .rd_addr (col_reg),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (sums),
        .rd_data (ls_rd_data)
    );

    assign above                 = s1_above_reg ? ls_rd_data : '0;
    assign sums.area_sum         = above.area_sum + AREA_SUM_W'(s1_rsum_reg);
    assign sums.area_square_sum  = above.area_square_sum + AREA_SQ_W'(s1_rsq_reg);

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= (CW+1)'(WIDTH_RESET);
            height_reg    <= (RW+1)'(HEIGHT_RESET);
            col_reg       <= '0;
            row_reg       <= '0;
            rsum_reg      <= '0;
            rsq_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            rsum_reg      <= rsum_next;
            rsq_reg       <= rsq_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_col_reg   <= col_reg;
            s1_rsum_reg  <= rsum_cur;
            s1_rsq_reg   <= rsq_cur;
            s1_above_reg <= (row_reg != '0);
            s1_last_reg  <= row_end && frame_end;
        end
        if (s1_adv)
        begin
            out_sums_reg <= sums;
            out_last_reg <= s1_last_reg;
        end
    end

    assign result_stream.valid           = out_valid_reg;
    assign result_stream.area_sum        = out_sums_reg.area_sum;
    assign result_stream.area_square_sum = out_sums_reg.area_square_sum;
    assign result_stream.frame_last      = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `IIG_ASSERT_NEXT(a_accept_fills_mid, in_acc, s1_valid_reg, "accepted item lost")
    `IIG_ASSERT_NEXT(a_first_row_masks, in_acc && (row_reg == '0), !s1_above_reg, "top row reads")
    `IIG_ASSERT_NEXT(a_frame_last, in_acc && row_end && frame_end, s1_last_reg, "no frame end")
    `IIG_ASSERT_SAME(a_mid_moves_on, s1_valid_reg && !out_valid_reg, s1_adv, "middle stage stuck")

endmodule

### rtl/iig_line_store.sv
// Line store holding the previous row's sums, with write-to-read forwarding.
module iig_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  iig_pkg::area_sums_t wr_data,
    output iig_pkg::area_sums_t rd_data
);
    import iig_pkg::*;

    area_sums_t mem [DEPTH];
    area_sums_t mem_q_reg;
    area_sums_t last_wr_reg;
    logic       hit_reg;
    logic       hit_next;

    // A read and a write to the same entry at one edge returns the old word,
    // so the written word is kept and selected instead.
    always_comb
    begin
        hit_next = hit_reg;
        if (rd_en)
        begin
            hit_next = wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
            last_wr_reg  <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign rd_data = hit_reg ? last_wr_reg : mem_q_reg;

endmodule
